>>> design/isotp_frame_reassembler_defines.svh
// ----------------------------------------------------------------------------
// ISO-TP reassembler assertion macros
// Checks used at the end of the top level; empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef ISOTP_FRAME_REASSEMBLER_DEFINES_SVH
`define ISOTP_FRAME_REASSEMBLER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, ignored during reset.
`define ISOTP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("isotp same-cycle check failed");
// Next-cycle implication, ignored during reset.
`define ISOTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("isotp next-cycle check failed");
`else
`define ISOTP_ASSERT_SAME(label, clk, rst, ante, cons)
`define ISOTP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> design/isotp_pkg.sv
// ----------------------------------------------------------------------------
// ISO-TP reassembler package
// Frame kinds, masks and the job descriptor passed from front to back.
// ----------------------------------------------------------------------------
package isotp_pkg;

   localparam logic [7:0] TYPE_MASK = 8'hF0;
   localparam logic [7:0] LOW_MASK  = 8'h0F;

   localparam int FRAME_BYTES = 7;    // data bytes after the PCI byte in a classic CAN frame
   localparam int FIRST_BYTES = 6;    // payload bytes in a first frame

   typedef enum logic [3:0] {
      KIND_SINGLE = 4'h0,
      KIND_FIRST  = 4'h1,
      KIND_CONSEC = 4'h2
   } frame_kind_type;

   // One frame's worth of output work.
   typedef struct packed {
      logic [FRAME_BYTES-1:0][7:0] data;   // data[0] goes out first
      logic [2:0]                  count;  // beats to emit, 1..7
      logic [11:0]                 start;  // offset of the first byte
      logic                        valid;  // 0 only for an empty single frame
      logic                        done;   // last beat completes a message
      logic [3:0]                  seq;
   } job_type;

endpackage

>>> design/isotp_front.sv
// ----------------------------------------------------------------------------
// ISO-TP front end
// Classify each frame, track message progress and build at most one output job.
// ----------------------------------------------------------------------------
module isotp_front import isotp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  pci_byte,
   input  logic [7:0]  byte_one,
   input  logic [7:0]  byte_two,
   input  logic [7:0]  byte_three,
   input  logic [7:0]  byte_four,
   input  logic [7:0]  byte_five,
   input  logic [7:0]  byte_six,
   input  logic [7:0]  byte_seven,
   output logic        push,
   output job_type     job
);

   logic [11:0] remaining_ff, remaining_in;
   logic [11:0] offset_ff, offset_in;
   logic [3:0]  nib;
   logic [11:0] total;
   logic [2:0]  take;
   logic [11:0] left;
   logic        emit;
   frame_kind_type kind;

   assign kind  = frame_kind_type'(4'((pci_byte & TYPE_MASK) >> 4));
   assign nib   = 4'(pci_byte & LOW_MASK);
   assign total = {nib, byte_one};
   assign take  = (remaining_ff > 12'd7) ? 3'd7 : remaining_ff[2:0];
   assign left  = remaining_ff - 12'(take);

   always_comb begin
      job          = '0;
      emit         = 1'b0;
      remaining_in = remaining_ff;
      offset_in    = offset_ff;
      unique case (kind)
         KIND_SINGLE: begin
            emit         = 1'b1;
            remaining_in = '0;
            offset_in    = '0;
            job.done     = 1'b1;
            if (nib == 4'd0) begin
               job.count = 3'd1;         // empty message: one marker beat
            end else begin
               job.valid = 1'b1;
               job.count = (nib > 4'd7) ? 3'd7 : nib[2:0];
               job.data  = {byte_seven, byte_six, byte_five, byte_four,
                            byte_three, byte_two, byte_one};
            end
         end
         KIND_FIRST: begin
            emit         = 1'b1;
            remaining_in = (total > 12'(FIRST_BYTES)) ? total - 12'(FIRST_BYTES) : '0;
            offset_in    = 12'(FIRST_BYTES);
            job.valid    = 1'b1;
            job.count    = 3'(FIRST_BYTES);
            job.data     = {8'h00, byte_seven, byte_six, byte_five, byte_four,
                            byte_three, byte_two};
         end
         KIND_CONSEC: begin
            if (remaining_ff != '0) begin
               emit         = 1'b1;
               remaining_in = left;
               offset_in    = offset_ff + 12'(take);
               job.valid    = 1'b1;
               job.count    = take;
               job.start    = offset_ff;
               job.done     = (left == '0);
               job.seq      = nib;
               job.data     = {byte_seven, byte_six, byte_five, byte_four,
                               byte_three, byte_two, byte_one};
            end
         end
         default: begin
            // flow control and unknown kinds: drop
         end
      endcase
   end

   assign push = accept & emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         offset_ff    <= '0;
      end else if (accept) begin
         remaining_ff <= remaining_in;
         offset_ff    <= offset_in;
      end
   end

endmodule

>>> design/isotp_queue.sv
// ----------------------------------------------------------------------------
// ISO-TP job queue
// Two-entry queue of frame jobs between the front and back ends.
// ----------------------------------------------------------------------------
module isotp_queue import isotp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output job_type head
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_pop;

   assign full       = (fill_ff == 2'd2);
   assign head_valid = (fill_ff != 2'd0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = push   ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> design/isotp_back.sv
// ----------------------------------------------------------------------------
// ISO-TP back end
// Walk the head job into the output register one byte per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module isotp_back import isotp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  job_type     head,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data_byte,
   output logic [11:0] rsp_byte_offset,
   output logic        rsp_byte_valid,
   output logic        rsp_last_of_frame,
   output logic        rsp_message_done,
   output logic [3:0]  rsp_seq_number
);

   logic [2:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [7:0]  data_ff;
   logic [11:0] offset_ff;
   logic        bvalid_ff, last_ff, done_ff;
   logic [3:0]  seq_ff;
   logic        load, step, last;

   assign load = ~valid_ff | ~rsp_stall;
   assign step = load & head_valid;
   assign last = (idx_ff == head.count - 3'd1);
   assign pop  = step & last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = head_valid;
      end
      if (step) begin
         idx_in = last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         data_ff   <= head.data[idx_ff];
         offset_ff <= head.start + 12'(idx_ff);
         bvalid_ff <= head.valid;
         last_ff   <= last;
         done_ff   <= last & head.done;
         seq_ff    <= head.seq;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_data_byte     = data_ff;
   assign rsp_byte_offset   = offset_ff;
   assign rsp_byte_valid    = bvalid_ff;
   assign rsp_last_of_frame = last_ff;
   assign rsp_message_done  = done_ff;
   assign rsp_seq_number    = seq_ff;

endmodule

>>> design/isotp_frame_reassembler.sv
// ----------------------------------------------------------------------------
// ISO-TP frame reassembler
// Turns received classic CAN frames into a stream of tagged payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one CAN frame per beat: the PCI byte and data bytes one to
//   seven. rsp_* carries one payload byte per beat with its message offset,
//   a frame-end mark, a message-done mark and the consecutive-frame sequence.
//   Single, first and consecutive frames emit 1..7 beats (an empty single
//   frame emits one beat with rsp_byte_valid low); flow-control, unknown and
//   orphan consecutive frames emit nothing.
//   Path: a frame's job is registered in the queue, then its first byte in the
//   back end's output register when the back end is free. Throughput: one
//   response beat per cycle while rsp_stall is low, so a frame holds the back
//   end for as many beats as it emits bytes (at most seven); the request side
//   takes a frame every cycle while the two-entry job queue has room.
//   Reset clears the message count and offset, empties the queue and drops
//   the response valid. When the receiver stalls, the response beat holds,
//   the queue fills, and req_stall rises once both entries are taken.
// ----------------------------------------------------------------------------
`include "isotp_frame_reassembler_defines.svh"

module isotp_frame_reassembler import isotp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pci_byte,
   input  logic [7:0]  req_byte_one,
   input  logic [7:0]  req_byte_two,
   input  logic [7:0]  req_byte_three,
   input  logic [7:0]  req_byte_four,
   input  logic [7:0]  req_byte_five,
   input  logic [7:0]  req_byte_six,
   input  logic [7:0]  req_byte_seven,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data_byte,
   output logic [11:0] rsp_byte_offset,
   output logic        rsp_byte_valid,
   output logic        rsp_last_of_frame,
   output logic        rsp_message_done,
   output logic [3:0]  rsp_seq_number
);

   logic    accept;
   logic    push;
   job_type push_job;
   logic    q_full;
   logic    head_valid;
   job_type head;
   logic    pop;

   // Hold the request side only while the queue is full.
   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;

   // Front: classify the frame, advance message state, build the job.
   isotp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .pci_byte   (req_pci_byte),
      .byte_one   (req_byte_one),
      .byte_two   (req_byte_two),
      .byte_three (req_byte_three),
      .byte_four  (req_byte_four),
      .byte_five  (req_byte_five),
      .byte_six   (req_byte_six),
      .byte_seven (req_byte_seven),
      .push       (push),
      .job        (push_job)
   );

   // Queue: decouple frame intake from byte emission.
   isotp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head)
   );

   // Back: emit the head job one byte per beat.
   isotp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_offset   (rsp_byte_offset),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_message_done  (rsp_message_done),
      .rsp_seq_number    (rsp_seq_number)
   );

   // Never push into a full queue.
   `ISOTP_ASSERT_SAME(a_no_overflow, clock, reset, q_full, !push)
   // A completed message always closes its frame.
   `ISOTP_ASSERT_SAME(a_done_is_last, clock, reset, rsp_valid && rsp_message_done, rsp_last_of_frame)
   // An empty marker beat is a whole message at offset zero.
   `ISOTP_ASSERT_SAME(a_empty_beat, clock, reset, rsp_valid && !rsp_byte_valid, rsp_message_done && rsp_last_of_frame && rsp_byte_offset == 12'd0)
   // A frame's beats run without a bubble once the first one is taken.
   `ISOTP_ASSERT_NEXT(a_frame_no_gap, clock, reset, rsp_valid && !rsp_stall && !rsp_last_of_frame, rsp_valid)

endmodule
